// ----- hw/rtl/tpp_pkg.sv -----
// shared types, constants and codes of the timed pulse pwm controller
`timescale 1ns / 1ps

package tpp_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_SLOTS     = 4;

    localparam int KIND_W     = 3;
    localparam int CHAN_W     = 2;
    localparam int FREQ_W     = 16;
    localparam int DUTY_W     = 8;
    localparam int DUR_W      = 8;
    localparam int PERIOD_W   = 16;
    localparam int CMP_W      = 17;
    localparam int DUTY_C_W   = 7;
    localparam int DIVIDEND_W = 23;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = 5;
    localparam int RECIP_W    = 24;
    localparam int SCALE_W    = DIVIDEND_W + RECIP_W;
    localparam int SCALE_SHIFT = 30;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 96;

    localparam logic [KIND_W-1:0] KIND_CONFIGURE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PULSE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP_ALL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK      = 3'd4;

    localparam logic [DIVIDEND_W-1:0] TIMER_CLOCK_HZ = 23'd1000000;
    localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 16'd999;
    localparam logic [PERIOD_W-1:0]   PERIOD_MAX     = 16'hFFFF;
    localparam logic [DUTY_C_W-1:0]   DUTY_MAX       = 7'd100;
    localparam logic [DIVISOR_W-1:0]  PERCENT_DIV    = 16'd100;
    // 2^30 / 100 rounded up, exact for any product below 2^23
    localparam logic [RECIP_W-1:0]    PERCENT_RECIP  = 24'd10737419;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic mul;
        logic commit;
        logic exec;
        logic refuse;
        logic emit;
    } tpp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              chan_ok;
        logic              cfg_ok;
        logic              div_done;
    } tpp_status_t;

endpackage

// ----- hw/rtl/tpp_div.sv -----
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tpp_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tpp_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [tpp_pkg::DIVISOR_W-1:0]    divisor,
    output logic [tpp_pkg::DIVIDEND_W-1:0]   quotient,
    output logic                             done
);

    logic [tpp_pkg::DIVIDEND_W-1:0] quo_reg;
    logic [tpp_pkg::DIVIDEND_W-1:0] quo_next;
    logic [tpp_pkg::DIVISOR_W:0]    rem_reg;
    logic [tpp_pkg::DIVISOR_W:0]    rem_next;
    logic [tpp_pkg::DIVISOR_W-1:0]  dvs_reg;
    logic [tpp_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           done_reg;
    logic [tpp_pkg::DIVISOR_W:0]    rem_shift;

    // shift in the next dividend bit and try a subtract
    always_comb
    begin
        rem_shift = {rem_reg[tpp_pkg::DIVISOR_W-1:0], quo_reg[tpp_pkg::DIVIDEND_W-1]};
        if (rem_shift >= {1'b0, dvs_reg})
        begin
            rem_next = rem_shift - {1'b0, dvs_reg};
            quo_next = {quo_reg[tpp_pkg::DIVIDEND_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift;
            quo_next = {quo_reg[tpp_pkg::DIVIDEND_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= tpp_pkg::DIV_CNT_W'(tpp_pkg::DIVIDEND_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tpp_pkg::DIV_CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- hw/rtl/tpp_datapath.sv -----
// channel state, duty scaling, period divider and result register
`timescale 1ns / 1ps

module tpp_datapath
#(
    parameter int NUM_CHANNELS = tpp_pkg::NUM_CHANNELS
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tpp_pkg::tpp_cmd_t                      cmd,
    output tpp_pkg::tpp_status_t                   status,
    input  logic [tpp_pkg::KIND_W-1:0]             kind,
    input  logic [tpp_pkg::CHAN_W-1:0]             channel,
    input  logic [tpp_pkg::FREQ_W-1:0]             frequency,
    input  logic [tpp_pkg::DUTY_W-1:0]             duty,
    input  logic [tpp_pkg::DUR_W-1:0]              duration,
    output logic [tpp_pkg::PERIOD_W-1:0]           period_value,
    output logic [tpp_pkg::CMP_W-1:0]              compare_ch0,
    output logic [tpp_pkg::CMP_W-1:0]              compare_ch1,
    output logic [tpp_pkg::CMP_W-1:0]              compare_ch2,
    output logic [tpp_pkg::CMP_W-1:0]              compare_ch3,
    output logic [tpp_pkg::CH_SLOTS-1:0]           enable_mask,
    output logic                                   applied
);

    localparam logic [tpp_pkg::CHAN_W:0] CH_LIMIT = (tpp_pkg::CHAN_W + 1)'(NUM_CHANNELS);

    // latched item
    logic [tpp_pkg::KIND_W-1:0]  kind_reg;
    logic [tpp_pkg::CHAN_W-1:0]  chan_reg;
    logic [tpp_pkg::FREQ_W-1:0]  freq_reg;
    logic [tpp_pkg::DUTY_W-1:0]  duty_reg;
    logic [tpp_pkg::DUR_W-1:0]   dur_reg;

    // controller state
    logic [tpp_pkg::PERIOD_W-1:0] period_reg;
    logic [tpp_pkg::CMP_W-1:0]    cmp_reg   [NUM_CHANNELS];
    logic [tpp_pkg::DUR_W-1:0]    ticks_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]      run_reg;
    logic                         applied_reg;

    logic [tpp_pkg::DIVIDEND_W-1:0] prod_reg;
    logic [tpp_pkg::DIVIDEND_W:0]   prod_full;
    logic [tpp_pkg::DUTY_C_W-1:0]   duty_c;
    logic [tpp_pkg::CMP_W-1:0]      period_plus;
    logic [tpp_pkg::SCALE_W-1:0]    scaled;
    logic [tpp_pkg::CMP_W-1:0]      duty_cmp;

    logic [tpp_pkg::DIVIDEND_W-1:0] div_quo;
    logic                           div_done;
    logic [tpp_pkg::DIVIDEND_W-1:0] quo_minus;
    logic [tpp_pkg::PERIOD_W-1:0]   period_calc;

    logic chan_ok;
    logic others_running;
    logic is_cfg;

    // result register
    logic [tpp_pkg::PERIOD_W-1:0] out_period_reg;
    logic [tpp_pkg::CMP_W-1:0]    out_cmp_reg [tpp_pkg::CH_SLOTS];
    logic [tpp_pkg::CH_SLOTS-1:0] out_mask_reg;
    logic                         out_applied_reg;
    logic [tpp_pkg::CMP_W-1:0]    slot_cmp    [tpp_pkg::CH_SLOTS];
    logic [tpp_pkg::CH_SLOTS-1:0] slot_mask;

    assign is_cfg  = (kind_reg == tpp_pkg::KIND_CONFIGURE);
    assign chan_ok = ({1'b0, chan_reg} < CH_LIMIT);

    always_comb
    begin
        others_running = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (run_reg[i] && (tpp_pkg::CHAN_W'(i) != chan_reg))
            begin
                others_running = 1'b1;
            end
        end
    end

    assign status.kind     = kind_reg;
    assign status.chan_ok  = chan_ok;
    assign status.cfg_ok   = chan_ok && (freq_reg != '0) && !others_running;
    assign status.div_done = div_done;

    // duty times counts per period, at most 100 * 65536
    assign duty_c      = (duty_reg > tpp_pkg::DUTY_W'(tpp_pkg::DUTY_MAX))
                         ? tpp_pkg::DUTY_MAX : duty_reg[tpp_pkg::DUTY_C_W-1:0];
    assign period_plus = {1'b0, period_reg} + tpp_pkg::CMP_W'(1);
    assign prod_full   = (tpp_pkg::DIVIDEND_W + 1)'(duty_c)
                         * (tpp_pkg::DIVIDEND_W + 1)'(period_plus);

    // divide by 100 as a multiply by the scaled reciprocal
    assign scaled   = tpp_pkg::SCALE_W'(prod_reg) * tpp_pkg::SCALE_W'(tpp_pkg::PERCENT_RECIP);
    assign duty_cmp = scaled[tpp_pkg::SCALE_SHIFT +: tpp_pkg::CMP_W];

    tpp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (tpp_pkg::TIMER_CLOCK_HZ),
        .divisor  (freq_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign quo_minus   = (div_quo != '0) ? div_quo - 1'b1 : '0;
    assign period_calc = (quo_minus > tpp_pkg::DIVIDEND_W'(tpp_pkg::PERIOD_MAX))
                         ? tpp_pkg::PERIOD_MAX : quo_minus[tpp_pkg::PERIOD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            chan_reg <= channel;
            freq_reg <= frequency;
            duty_reg <= duty;
            dur_reg  <= duration;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[tpp_pkg::DIVIDEND_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= tpp_pkg::PERIOD_RESET;
            run_reg     <= '0;
            applied_reg <= 1'b1;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cmp_reg[i]   <= '0;
                ticks_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                applied_reg <= 1'b1;
            end
            if (cmd.refuse)
            begin
                applied_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                if (is_cfg)
                begin
                    period_reg <= period_calc;
                end
                else
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if (tpp_pkg::CHAN_W'(i) == chan_reg)
                        begin
                            cmp_reg[i]   <= duty_cmp;
                            ticks_reg[i] <= dur_reg;
                            run_reg[i]   <= 1'b1;
                        end
                    end
                end
            end
            if (cmd.exec)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    case (kind_reg)
                        tpp_pkg::KIND_STOP:
                        begin
                            if (tpp_pkg::CHAN_W'(i) == chan_reg)
                            begin
                                ticks_reg[i] <= '0;
                                run_reg[i]   <= 1'b0;
                            end
                        end
                        tpp_pkg::KIND_STOP_ALL:
                        begin
                            ticks_reg[i] <= '0;
                            run_reg[i]   <= 1'b0;
                        end
                        tpp_pkg::KIND_TICK:
                        begin
                            // continuous channels hold a zero count and are left alone
                            if (ticks_reg[i] != '0)
                            begin
                                ticks_reg[i] <= ticks_reg[i] - 1'b1;
                                if (ticks_reg[i] == tpp_pkg::DUR_W'(1))
                                begin
                                    run_reg[i] <= 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // slots beyond the channel count read as zero
    for (genvar g = 0; g < tpp_pkg::CH_SLOTS; g++)
    begin : g_slot
        if (g < NUM_CHANNELS)
        begin : g_used
            assign slot_cmp[g]  = cmp_reg[g];
            assign slot_mask[g] = run_reg[g];
        end
        else
        begin : g_unused
            assign slot_cmp[g]  = '0;
            assign slot_mask[g] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_period_reg  <= period_reg;
            out_mask_reg    <= slot_mask;
            out_applied_reg <= applied_reg;
            for (int i = 0; i < tpp_pkg::CH_SLOTS; i++)
            begin
                out_cmp_reg[i] <= slot_cmp[i];
            end
        end
    end

    assign period_value = out_period_reg;
    assign compare_ch0  = out_cmp_reg[0];
    assign compare_ch1  = out_cmp_reg[1];
    assign compare_ch2  = out_cmp_reg[2];
    assign compare_ch3  = out_cmp_reg[3];
    assign enable_mask  = out_mask_reg;
    assign applied      = out_applied_reg;

endmodule

// ----- hw/rtl/tpp_ctrl.sv -----
// sequencing state machine of the pwm controller
`timescale 1ns / 1ps

module tpp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tpp_pkg::tpp_cmd_t    cmd,
    input  tpp_pkg::tpp_status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_SCALE  = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.kind)
                    tpp_pkg::KIND_CONFIGURE:
                    begin
                        if (status.cfg_ok)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_WAIT;
                        end
                        else
                        begin
                            cmd.refuse = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                    tpp_pkg::KIND_PULSE:
                    begin
                        state_next = status.chan_ok ? ST_MUL : ST_EMIT;
                    end
                    default:
                    begin
                        cmd.exec   = 1'b1;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                // reciprocal multiply settles within this cycle
                cmd.commit = 1'b1;
                state_next = ST_EMIT;
            end
            ST_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/timed_pulse_pwm_controller_core.sv -----
// Top level of the timed pulse pwm controller.
// Input beats on s_axis carry one command each: tuser is the kind (configure,
// pulse, stop, stop all, one millisecond tick), tdata the channel, frequency,
// duty and duration. Every accepted beat yields exactly one result beat on
// m_axis with the shared period, the four compare values, the enable mask
// and an applied flag (low when a configure was refused).
// Stop, stop all, tick, unused kinds and refused or out-of-range commands go
// from decode straight to emit, where m_axis_tvalid is set; a pulse passes the
// multiply and scale states first, as its divide by 100 is a reciprocal
// multiply; a configure waits for the 23-step serial divider and its commit.
// One command is worked on at a time; s_axis_tready is high only while the
// sequencer is idle, so a new beat is taken once the last one has been emitted.
// tready is also high while a result waits in the output register.
// When m_axis stalls, the finished result stays in the output register and
// the next command is still taken; its result waits until the register frees,
// and the input stalls meanwhile.
// Reset clears all channels to stopped with zero compare values, sets the
// period to 999 and empties the output register.
`timescale 1ns / 1ps

module timed_pulse_pwm_controller_core
#(
    parameter int NUM_CHANNELS = tpp_pkg::NUM_CHANNELS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // channel, frequency, duty, duration, zero pad
    input  logic [tpp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind
    input  logic [tpp_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // period_value, compare_ch0..compare_ch3, enable_mask, applied, zero pad
    output logic [tpp_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    tpp_pkg::tpp_cmd_t    cmd;
    tpp_pkg::tpp_status_t status;

    logic [tpp_pkg::PERIOD_W-1:0] period_value;
    logic [tpp_pkg::CMP_W-1:0]    compare_ch0;
    logic [tpp_pkg::CMP_W-1:0]    compare_ch1;
    logic [tpp_pkg::CMP_W-1:0]    compare_ch2;
    logic [tpp_pkg::CMP_W-1:0]    compare_ch3;
    logic [tpp_pkg::CH_SLOTS-1:0] enable_mask;
    logic                         applied;

    tpp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    tpp_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (s_axis_tuser),
        .channel      (s_axis_tdata[1:0]),
        .frequency    (s_axis_tdata[17:2]),
        .duty         (s_axis_tdata[25:18]),
        .duration     (s_axis_tdata[33:26]),
        .period_value (period_value),
        .compare_ch0  (compare_ch0),
        .compare_ch1  (compare_ch1),
        .compare_ch2  (compare_ch2),
        .compare_ch3  (compare_ch3),
        .enable_mask  (enable_mask),
        .applied      (applied)
    );

    assign m_axis_tdata = {7'd0, applied, enable_mask, compare_ch3, compare_ch2,
                           compare_ch1, compare_ch0, period_value};

endmodule
